@@ rtl/pps_pkg.sv @@
package pps_pkg;

  localparam int COEF_W    = 32;
  localparam int IDX_W     = 6;
  localparam int LEN_W     = 6;
  localparam int LEN_RESET = 32;
  localparam int IN_W      = 2 * COEF_W;
  localparam int OUT_W     = 40;
  localparam int OUT_PAD   = OUT_W - COEF_W - IDX_W;

  typedef logic [COEF_W-1:0] coef_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // one multiply-accumulate issued to the datapath
  typedef struct packed {
    logic             vld;
    logic             first;  // first touch of this accumulator in the product
    logic [IDX_W-1:0] k;
  } mac_op_t;

endpackage

@@ rtl/pps_ram.sv @@
module pps_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/pps_mac.sv @@
module pps_mac #(
  parameter int KW = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pps_pkg::mac_op_t  op_in,
  input  pps_pkg::coef_t    a_rdata,
  input  pps_pkg::coef_t    b_rdata,
  input  pps_pkg::coef_t    acc_rdata,
  output logic              acc_we,
  output logic [KW-1:0]     acc_waddr,
  output pps_pkg::coef_t    acc_wdata,
  output logic              busy
);
  import pps_pkg::*;

  mac_op_t       op1_r;
  mac_op_t       op2_r;
  coef_t         prod_lo;
  coef_t         prod_r;
  coef_t         accv_r;
  coef_t         base;
  logic          w1_vld_r;
  logic          w2_vld_r;
  logic [KW-1:0] w1_k_r;
  logic [KW-1:0] w2_k_r;
  coef_t         w1_d_r;
  coef_t         w2_d_r;

  assign prod_lo = a_rdata * b_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op1_r    <= '0;
      op2_r    <= '0;
      w1_vld_r <= 1'b0;
      w2_vld_r <= 1'b0;
    end else begin
      op1_r    <= op_in;
      op2_r    <= op1_r;
      w1_vld_r <= op2_r.vld;
      w2_vld_r <= w1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_lo;
    accv_r <= acc_rdata;
    w1_k_r <= acc_waddr;
    w1_d_r <= acc_wdata;
    w2_k_r <= w1_k_r;
    w2_d_r <= w1_d_r;
  end

  // the two writes that landed after this entry was read are forwarded
  always_comb begin
    priority if (op2_r.first) begin
      base = '0;
    end else if (w1_vld_r && w1_k_r == acc_waddr) begin
      base = w1_d_r;
    end else if (w2_vld_r && w2_k_r == acc_waddr) begin
      base = w2_d_r;
    end else begin
      base = accv_r;
    end
  end

  assign acc_waddr = op2_r.k[KW-1:0];
  assign acc_wdata = base + prod_r;
  assign acc_we    = op2_r.vld;
  assign busy      = op1_r.vld | op2_r.vld;

endmodule

@@ rtl/pps_ctrl.sv @@
module pps_ctrl #(
  parameter int MAX_LEN = 32,
  parameter int AW      = 5,
  parameter int KW      = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [pps_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output pps_pkg::coef_t           out_coef,
  output logic [pps_pkg::IDX_W-1:0] out_idx,
  output logic                     out_tlast,
  output logic                     ab_we,
  output logic [AW-1:0]            ab_waddr,
  output logic                     ab_re,
  output logic [AW-1:0]            a_raddr,
  output logic [AW-1:0]            b_raddr,
  output logic                     acc_re,
  output logic [KW-1:0]            acc_raddr,
  input  pps_pkg::coef_t           acc_rdata,
  output pps_pkg::mac_op_t         mac_op,
  input  logic                     mac_busy
);
  import pps_pkg::*;

  localparam int RST_LEN = (LEN_RESET > MAX_LEN) ? MAX_LEN : LEN_RESET;
  localparam logic [AW-1:0] RST_NM1 = AW'(RST_LEN - 1);
  localparam logic [AW-1:0] MAX_NM1 = AW'(MAX_LEN - 1);
  localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(MAX_LEN);
  localparam logic [LEN_W-1:0] ONE_V = LEN_W'(1);

  state_t           state_r;
  state_t           state_nxt;
  logic [AW-1:0]    n_m1_r;
  logic [AW-1:0]    cfg_nm1;
  logic [AW-1:0]    load_cnt_r;
  logic [AW-1:0]    i_r;
  logic [AW-1:0]    j_r;
  logic [KW-1:0]    k;
  logic [KW-1:0]    last_idx;
  logic [KW-1:0]    emit_cnt_r;
  logic             emit_done_r;
  logic             rd_v_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_last_r;
  logic             out_v_r;
  coef_t            out_coef_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_last_r;
  logic             load_last;
  logic             in_acc;
  logic             mac_issue;
  logic             mv;
  logic             emit_issue;

  always_comb begin
    priority if (cfg_wr_data == '0) begin
      cfg_nm1 = '0;
    end else if (cfg_wr_data > MAX_LEN_V) begin
      cfg_nm1 = MAX_NM1;
    end else begin
      cfg_nm1 = AW'(cfg_wr_data - ONE_V);
    end
  end

  assign load_last = (load_cnt_r == n_m1_r);
  assign in_acc    = in_tvalid && in_tready;
  assign k         = KW'(i_r) + KW'(j_r);
  assign last_idx  = KW'({n_m1_r, 1'b0});
  assign mv        = rd_v_r && (!out_v_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && load_last) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (i_r == n_m1_r && j_r == n_m1_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done_r && !rd_v_r) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // loading the next operands overlaps readout, all but the final pair
  always_comb begin
    in_tready  = 1'b0;
    mac_issue  = 1'b0;
    emit_issue = 1'b0;
    unique case (state_r)
      ST_LOAD:  in_tready = 1'b1;
      ST_MAC:   mac_issue = 1'b1;
      ST_DRAIN: in_tready = 1'b0;
      ST_EMIT: begin
        in_tready  = !load_last;
        emit_issue = !emit_done_r && (!rd_v_r || mv);
      end
      default: in_tready = 1'b0;
    endcase
  end

  assign ab_we     = in_acc;
  assign ab_waddr  = load_cnt_r;
  assign ab_re     = mac_issue;
  assign a_raddr   = i_r;
  assign b_raddr   = j_r;
  assign acc_re    = mac_issue || emit_issue;
  assign acc_raddr = mac_issue ? k : emit_cnt_r;

  assign mac_op.vld   = mac_issue;
  assign mac_op.first = (i_r == '0) || (j_r == n_m1_r);
  assign mac_op.k     = IDX_W'(k);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      n_m1_r      <= RST_NM1;
      load_cnt_r  <= '0;
      i_r         <= '0;
      j_r         <= '0;
      emit_cnt_r  <= '0;
      emit_done_r <= 1'b0;
      rd_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        n_m1_r     <= cfg_nm1;
        load_cnt_r <= '0;
      end else if (in_acc) begin
        load_cnt_r <= load_last ? '0 : load_cnt_r + 1'b1;
      end
      if (state_r == ST_LOAD) begin
        i_r <= '0;
        j_r <= '0;
      end else if (mac_issue) begin
        if (j_r == n_m1_r) begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      if (state_r != ST_EMIT) begin
        emit_cnt_r  <= '0;
        emit_done_r <= 1'b0;
      end else if (emit_issue) begin
        if (emit_cnt_r == last_idx) begin
          emit_done_r <= 1'b1;
        end else begin
          emit_cnt_r <= emit_cnt_r + 1'b1;
        end
      end
      if (emit_issue) begin
        rd_v_r <= 1'b1;
      end else if (mv) begin
        rd_v_r <= 1'b0;
      end
      if (mv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_issue) begin
      rd_idx_r  <= IDX_W'(emit_cnt_r);
      rd_last_r <= (emit_cnt_r == last_idx);
    end
    if (mv) begin
      out_coef_r <= acc_rdata;
      out_idx_r  <= rd_idx_r;
      out_last_r <= rd_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_coef   = out_coef_r;
  assign out_idx    = out_idx_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_load_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= n_m1_r)
    else $error("load count beyond operand length");

  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_v_r && !mv) |=> rd_v_r)
    else $error("readout item lost");

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !mac_busy)
    else $error("readout while accumulation in flight");
`endif

endmodule

@@ rtl/polynomial_product_schoolbook_unit.sv @@
// Loads n coefficient pairs at one item per cycle, then runs n*n multiply-accumulates
// through one shared MAC on the accumulator RAM, one per cycle.
// The 2n-1 results then follow, one per cycle while out_tready stays high.
// Next-product pairs load during readout, all but the last; none during the MAC loop.
// Reset (rst_n, sync) clears control and sets length 32; coefficient RAMs are not cleared.
module polynomial_product_schoolbook_unit #(
  parameter int MAX_LEN = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [pps_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [pps_pkg::IN_W-1:0]  in_tdata,   // a_coef, b_coef
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [pps_pkg::OUT_W-1:0] out_tdata,  // product_coef, coef_index, zero pad
  output logic                      out_tlast
);
  import pps_pkg::*;

  localparam int AW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ACC_DEPTH = 2 * MAX_LEN - 1;
  localparam int KW        = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;

  logic             ab_we;
  logic [AW-1:0]    ab_waddr;
  logic             ab_re;
  logic [AW-1:0]    a_raddr;
  logic [AW-1:0]    b_raddr;
  coef_t            a_rdata;
  coef_t            b_rdata;
  logic             acc_re;
  logic [KW-1:0]    acc_raddr;
  coef_t            acc_rdata;
  logic             acc_we;
  logic [KW-1:0]    acc_waddr;
  coef_t            acc_wdata;
  mac_op_t          mac_op;
  logic             mac_busy;
  coef_t            out_coef;
  logic [IDX_W-1:0] out_idx;

  pps_ram #(.W(COEF_W), .DEPTH(MAX_LEN), .AW(AW)) u_a_ram (
    .clk   (clk),
    .we    (ab_we),
    .waddr (ab_waddr),
    .wdata (in_tdata[COEF_W-1:0]),
    .re    (ab_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  pps_ram #(.W(COEF_W), .DEPTH(MAX_LEN), .AW(AW)) u_b_ram (
    .clk   (clk),
    .we    (ab_we),
    .waddr (ab_waddr),
    .wdata (in_tdata[IN_W-1:COEF_W]),
    .re    (ab_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  pps_ram #(.W(COEF_W), .DEPTH(ACC_DEPTH), .AW(KW)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  pps_mac #(.KW(KW)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_in     (mac_op),
    .a_rdata   (a_rdata),
    .b_rdata   (b_rdata),
    .acc_rdata (acc_rdata),
    .acc_we    (acc_we),
    .acc_waddr (acc_waddr),
    .acc_wdata (acc_wdata),
    .busy      (mac_busy)
  );

  pps_ctrl #(.MAX_LEN(MAX_LEN), .AW(AW), .KW(KW)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_coef    (out_coef),
    .out_idx     (out_idx),
    .out_tlast   (out_tlast),
    .ab_we       (ab_we),
    .ab_waddr    (ab_waddr),
    .ab_re       (ab_re),
    .a_raddr     (a_raddr),
    .b_raddr     (b_raddr),
    .acc_re      (acc_re),
    .acc_raddr   (acc_raddr),
    .acc_rdata   (acc_rdata),
    .mac_op      (mac_op),
    .mac_busy    (mac_busy)
  );

  assign out_tdata = {{OUT_PAD{1'b0}}, out_idx, out_coef};

endmodule

@@ verif/tb_polynomial_product_schoolbook_unit.sv @@
module tb_polynomial_product_schoolbook_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam int MAX_LEN     = 32;
  localparam int ITEM_TARGET = 380;
  localparam int CYCLE_LIMIT = 600000;

  localparam coef_t C_MAX  = 32'h7fff_ffff;
  localparam coef_t C_MIN  = 32'h8000_0000;
  localparam coef_t C_ZERO = 32'h0000_0000;
  localparam coef_t C_NEG1 = 32'hffff_ffff;
  localparam coef_t C_ONE  = 32'h0000_0001;

  typedef struct {
    coef_t a;
    coef_t b;
  } coef_pair_t;

  typedef struct {
    coef_t            coef;
    logic [IDX_W-1:0] idx;
    logic             last;
  } product_coef_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata    = '0;  // a_coef, b_coef
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // product_coef, coef_index, zero pad
  logic             out_tlast;

  coef_pair_t    pair_q[$];
  product_coef_t product_q[$];

  // predictor state
  coef_t            a_mem[MAX_LEN];
  coef_t            b_mem[MAX_LEN];
  logic [LEN_W-1:0] len_reg      = LEN_W'(LEN_RESET);
  int unsigned      pairs_loaded = 0;

  int unsigned in_gap     = 0;
  int unsigned out_stall  = 0;
  bit          in_burst   = 1'b0;
  bit          out_burst  = 1'b0;
  int unsigned cycle_cnt  = 0;
  int unsigned err_cnt    = 0;
  int unsigned items_in   = 0;
  int unsigned products   = 0;
  int unsigned coefs_seen = 0;
  int unsigned len_writes = 0;

  polynomial_product_schoolbook_unit #(.MAX_LEN(MAX_LEN)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned eff_len(logic [LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_LEN) return MAX_LEN;
    return v;
  endfunction

  // store one pair; a completed load pushes the full convolution
  function automatic void load_pair(coef_pair_t p);
    int unsigned   n;
    int unsigned   slot;
    coef_t         acc[2*MAX_LEN-1];
    product_coef_t r;
    n    = eff_len(len_reg);
    slot = pairs_loaded;
    if (slot >= n) slot = 0;
    a_mem[slot]  = p.a;
    b_mem[slot]  = p.b;
    pairs_loaded = slot + 1;
    items_in++;
    if (pairs_loaded < n) return;
    pairs_loaded = 0;
    products++;
    for (int k = 0; k < 2*MAX_LEN-1; k++) acc[k] = '0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc[i+j] = acc[i+j] + a_mem[i] * b_mem[j];
      end
    end
    for (int k = 0; k < 2*n-1; k++) begin
      r.coef = acc[k];
      r.idx  = IDX_W'(k);
      r.last = (k == 2*n-2);
      product_q.push_back(r);
    end
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(0, 7))
      0: return C_MAX;
      1: return C_MIN;
      2: return C_ZERO;
      3: return C_NEG1;
      4: return coef_t'($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_idle();
    while (pair_q.size() != 0 || in_tvalid || product_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_length(logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    len_reg      = v;
    pairs_loaded = 0;
    len_writes++;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // input driver
  always @(posedge clk) begin : feed
    coef_pair_t p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        p.a = in_tdata[COEF_W-1:0];
        p.b = in_tdata[IN_W-1:COEF_W];
        load_pair(p);
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pair_q.size() != 0) begin
          p = pair_q.pop_front();
          in_tdata  <= {p.b, p.a};
          in_tvalid <= 1'b1;
          in_gap    <= in_burst ? 0 : $urandom_range(0, 7);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check
    product_coef_t    want;
    coef_t            got_coef;
    logic [IDX_W-1:0] got_idx;
    int unsigned      s;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else begin
      s = (out_stall != 0) ? out_stall - 1 : 0;
      if (out_tvalid && out_tready) begin
        got_coef = out_tdata[COEF_W-1:0];
        got_idx  = out_tdata[COEF_W+IDX_W-1:COEF_W];
        coefs_seen++;
        if (product_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected item: coef %h idx %0d last %b", got_coef, got_idx, out_tlast);
        end else begin
          want = product_q.pop_front();
          if (got_coef !== want.coef || got_idx !== want.idx || out_tlast !== want.last) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: exp coef %h idx %0d last %b, got coef %h idx %0d last %b",
                       want.coef, want.idx, want.last, got_coef, got_idx, out_tlast);
          end
        end
        s = out_burst ? 0 : $urandom_range(0, 7);
      end
      out_stall  <= s;
      out_tready <= (s == 0);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, product_q.size());
      $display("[polynomial_product_schoolbook_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned      n;
    int unsigned      nprod;
    int unsigned      sent;
    int unsigned      ph;
    logic [LEN_W-1:0] len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // partial load at reset length, dropped by the write
    repeat (3) pair_q.push_back('{a: rand_coef(), b: rand_coef()});
    wait_idle();
    set_length(0);  // acts as 1

    pair_q.push_back('{a: C_ZERO, b: C_ZERO});
    pair_q.push_back('{a: C_MAX,  b: C_MAX});
    pair_q.push_back('{a: C_MIN,  b: C_MIN});
    pair_q.push_back('{a: C_MIN,  b: C_MAX});
    pair_q.push_back('{a: C_NEG1, b: C_NEG1});
    pair_q.push_back('{a: C_MAX,  b: C_NEG1});
    wait_idle();

    set_length(3);
    pair_q.push_back('{a: C_MAX, b: C_MIN});
    pair_q.push_back('{a: C_ONE, b: C_NEG1});
    wait_idle();
    set_length(2);  // drops the two pending pairs
    pair_q.push_back('{a: C_MAX,  b: C_MIN});
    pair_q.push_back('{a: C_MIN,  b: C_MAX});
    pair_q.push_back('{a: C_NEG1, b: C_ONE});
    pair_q.push_back('{a: C_MAX,  b: C_MAX});
    sent = 15;

    ph = 0;
    while (sent < ITEM_TARGET) begin
      if (ph == 0) len = 6'd63;
      else if (ph == 1) len = 6'd32;
      else begin
        case ($urandom_range(0, 11))
          0: len = 6'd32;
          1: len = LEN_W'($urandom_range(33, 63));
          default: len = LEN_W'($urandom_range(0, 12));
        endcase
      end
      ph++;
      wait_idle();
      set_length(len);
      n         = eff_len(len);
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      nprod     = (n >= 16) ? 1 : $urandom_range(1, 4);
      repeat (nprod * n) begin
        pair_q.push_back('{a: rand_coef(), b: rand_coef()});
        sent++;
      end
      if (n > 1 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, n - 1)) begin
          pair_q.push_back('{a: rand_coef(), b: rand_coef()});
          sent++;
        end
      end
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (product_q.size() != 0) begin
      $display("%0d expected results never arrived", product_q.size());
      err_cnt += product_q.size();
    end
    $display("loaded %0d coefficient pairs over %0d length writes, %0d products",
             items_in, len_writes, products);
    $display("checked %0d product coefficients, %0d mismatches", coefs_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("[polynomial_product_schoolbook_unit] OK");
    end else begin
      $display("[polynomial_product_schoolbook_unit] ERROR");
    end
    $finish;
  end

endmodule
